>>> src/eaq_pkg.sv
// ----------------------------------------------------------------------------
// eaq_pkg: shared constants for the Euler angle to quaternion converter
// Widths, CORDIC settings and the arctangent table.
// ----------------------------------------------------------------------------
package eaq_pkg;

    localparam int ANGLE_WIDTH     = 16;
    localparam int COMPONENT_WIDTH = 16;
    localparam int FRAC_BITS       = COMPONENT_WIDTH - 1;
    localparam int INNER_FRAC      = 32;
    localparam int CORDIC_STEPS    = 31;
    localparam int CORDIC_WIDTH    = 35;
    localparam int ROUND_SHIFT     = INNER_FRAC - FRAC_BITS;
    localparam int ANGLE_SHIFT     = 32 - ANGLE_WIDTH;
    // CORDIC stages, the rounding register, three product/sum stages
    localparam int LATENCY         = CORDIC_STEPS + 4;

    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_START = 35'sd2608131496;

    typedef logic [31:0] t_atan_table [CORDIC_STEPS];

    // atan(2^-i), 2^32 is a full turn
    localparam t_atan_table ATAN_TURN = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001
    };

endpackage

>>> src/eaq_cordic.sv
// ----------------------------------------------------------------------------
// eaq_cordic: pipelined half-angle cosine and sine
// One rotation step per register stage, then round and saturate to Q1.F.
// ----------------------------------------------------------------------------
module eaq_cordic (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic signed [eaq_pkg::ANGLE_WIDTH-1:0]     i_angle,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_cos,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_sin
);
    localparam int W  = eaq_pkg::CORDIC_WIDTH;
    localparam int N  = eaq_pkg::CORDIC_STEPS;
    localparam int CW = eaq_pkg::COMPONENT_WIDTH;
    localparam int RS = eaq_pkg::ROUND_SHIFT;
    localparam logic signed [W-1:0] C_RND = W'(1) <<< (RS - 1);
    localparam logic signed [W-1:0] C_MAX = (W'(1) <<< eaq_pkg::FRAC_BITS) - W'(1);
    localparam logic signed [W-1:0] C_MIN = -(W'(1) <<< eaq_pkg::FRAC_BITS);

    logic signed [W-1:0] r_x [N];
    logic signed [W-1:0] r_y [N];
    logic signed [W-1:0] r_z [N];
    logic signed [W-1:0] w_z0;

    // half angle: 2^33 is a full turn
    assign w_z0 = W'(i_angle) <<< eaq_pkg::ANGLE_SHIFT;

    for (genvar g = 0; g < N; g++) begin : g_step
        logic signed [W-1:0] w_xi, w_yi, w_zi, w_step;
        if (g == 0) begin : g_first
            assign w_xi = eaq_pkg::CORDIC_START;
            assign w_yi = '0;
            assign w_zi = w_z0;
        end else begin : g_next
            assign w_xi = r_x[g-1];
            assign w_yi = r_y[g-1];
            assign w_zi = r_z[g-1];
        end
        assign w_step = $signed(W'(eaq_pkg::ATAN_TURN[g])) <<< 1;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_zi[W-1]) begin
                    r_x[g] <= w_xi - (w_yi >>> g);
                    r_y[g] <= w_yi + (w_xi >>> g);
                    r_z[g] <= w_zi - w_step;
                end else begin
                    r_x[g] <= w_xi + (w_yi >>> g);
                    r_y[g] <= w_yi - (w_xi >>> g);
                    r_z[g] <= w_zi + w_step;
                end
            end
        end
    end

    logic signed [W-1:0] w_xr, w_yr;
    logic signed [CW-1:0] n_cos, n_sin;

    assign w_xr = (r_x[N-1] + C_RND) >>> RS;
    assign w_yr = (r_y[N-1] + C_RND) >>> RS;

    always_comb begin
        if (w_xr > C_MAX)      n_cos = C_MAX[CW-1:0];
        else if (w_xr < C_MIN) n_cos = C_MIN[CW-1:0];
        else                   n_cos = w_xr[CW-1:0];
        if (w_yr > C_MAX)      n_sin = C_MAX[CW-1:0];
        else if (w_yr < C_MIN) n_sin = C_MIN[CW-1:0];
        else                   n_sin = w_yr[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= n_cos;
            o_sin <= n_sin;
        end
    end

endmodule

>>> src/eaq_combine.sv
// ----------------------------------------------------------------------------
// eaq_combine: quaternion triple products
// Pair products, rounded third-factor products, then sum and saturate.
// ----------------------------------------------------------------------------
module eaq_combine (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] i_cx,
    input  logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] i_sx,
    input  logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] i_cy,
    input  logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] i_sy,
    input  logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] i_cz,
    input  logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] i_sz,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_w,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_x,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_y,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_z
);
    localparam int CW = eaq_pkg::COMPONENT_WIDTH;
    localparam int F  = eaq_pkg::FRAC_BITS;
    localparam int PW = 2 * CW;
    localparam int QW = 2 * CW + 1;
    localparam int SW = CW + 2;
    localparam logic signed [PW-1:0] C_RND_P = PW'(1) <<< (F - 1);
    localparam logic signed [QW-1:0] C_RND_Q = QW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] C_MAX = (SW'(1) <<< F) - SW'(1);
    localparam logic signed [SW-1:0] C_MIN = -(SW'(1) <<< F);

    // stage 1: cx*cy, sx*sy, sx*cy, cx*sy
    logic signed [PW-1:0] r_p [4];
    logic signed [CW-1:0] r_cz, r_sz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_cx * i_cy;
            r_p[1] <= i_sx * i_sy;
            r_p[2] <= i_sx * i_cy;
            r_p[3] <= i_cx * i_sy;
            r_cz   <= i_cz;
            r_sz   <= i_sz;
        end
    end

    // stage 2: round pair products, apply the z factor
    logic signed [PW-1:0] w_pr [4];
    logic signed [CW:0]   w_pn [4];
    logic signed [QW-1:0] r_q  [8];

    for (genvar g = 0; g < 4; g++) begin : g_rnd
        assign w_pr[g] = (r_p[g] + C_RND_P) >>> F;
        assign w_pn[g] = w_pr[g][CW:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= w_pn[0] * r_cz;
            r_q[1] <= w_pn[1] * r_sz;
            r_q[2] <= w_pn[2] * r_cz;
            r_q[3] <= w_pn[3] * r_sz;
            r_q[4] <= w_pn[3] * r_cz;
            r_q[5] <= w_pn[2] * r_sz;
            r_q[6] <= w_pn[0] * r_sz;
            r_q[7] <= w_pn[1] * r_cz;
        end
    end

    // stage 3: round, sum, saturate
    logic signed [QW-1:0] w_qr [8];
    logic signed [SW-1:0] w_qn [8];
    logic signed [SW-1:0] w_sum [4];
    logic signed [CW-1:0] n_out [4];

    for (genvar g = 0; g < 8; g++) begin : g_qrnd
        assign w_qr[g] = (r_q[g] + C_RND_Q) >>> F;
        assign w_qn[g] = SW'($signed(w_qr[g][CW:0]));
    end

    assign w_sum[0] = w_qn[0] + w_qn[1];
    assign w_sum[1] = w_qn[2] - w_qn[3];
    assign w_sum[2] = w_qn[4] + w_qn[5];
    assign w_sum[3] = w_qn[6] - w_qn[7];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (w_sum[k] > C_MAX)      n_out[k] = C_MAX[CW-1:0];
            else if (w_sum[k] < C_MIN) n_out[k] = C_MIN[CW-1:0];
            else                       n_out[k] = w_sum[k][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= n_out[0];
            o_x <= n_out[1];
            o_y <= n_out[2];
            o_z <= n_out[3];
        end
    end

endmodule

>>> src/euler_angles_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion: XYZ Euler angles to unit quaternion
// Fully pipelined CORDIC half-angle trig followed by triple products.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one beat of three signed
//   binary angles (full scale is plus or minus pi). Output channel:
//   o_out_valid / i_out_ready carry one beat of four Q1.15 components
//   (w, x, y, z), each rounded to nearest and saturated.
//   The pipeline has 31 CORDIC rotation stages (one per step, three
//   angle lanes side by side), one round-and-saturate register for the
//   cosines and sines, two product stages and one sum/saturate stage.
//   Throughput is one beat per cycle while the receiver does not stall;
//   each product stage holds one multiplier per term, so nothing is shared.
//   Reset clears only the valid bits that travel with each stage; data
//   registers are not reset. The block holds no state between beats.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_in_ready drops; beats in flight are neither lost nor
//   repeated, and bubbles behind the stalled head keep their slots.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic signed [eaq_pkg::ANGLE_WIDTH-1:0]     i_angle_x,
    input  logic signed [eaq_pkg::ANGLE_WIDTH-1:0]     i_angle_y,
    input  logic signed [eaq_pkg::ANGLE_WIDTH-1:0]     i_angle_z,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_quat_w,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_quat_x,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_quat_y,
    output logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] o_quat_z
);
    localparam int L  = eaq_pkg::LATENCY;
    localparam int CW = eaq_pkg::COMPONENT_WIDTH;

    logic         w_en;
    logic [L-1:0] r_vld;
    logic signed [CW-1:0] w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;

    // advance whenever the head slot is empty or being taken
    assign w_en        = !r_vld[L-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_in_valid};
        end
    end

    eaq_cordic u_cordic_x (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_x), .o_cos(w_cx), .o_sin(w_sx)
    );
    eaq_cordic u_cordic_y (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_y), .o_cos(w_cy), .o_sin(w_sy)
    );
    eaq_cordic u_cordic_z (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_z), .o_cos(w_cz), .o_sin(w_sz)
    );

    eaq_combine u_combine (
        .i_clk(i_clk), .i_en(w_en),
        .i_cx(w_cx), .i_sx(w_sx), .i_cy(w_cy), .i_sy(w_sy), .i_cz(w_cz), .i_sz(w_sz),
        .o_w(o_quat_w), .o_x(o_quat_x), .o_y(o_quat_y), .o_z(o_quat_z)
    );

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_valid_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> (r_vld[L-1:1] == $past(r_vld[L-2:0])))
        else $error("valid bits did not advance with the data");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_quat_w)
            && $stable(o_quat_x) && $stable(o_quat_y) && $stable(o_quat_z)))
        else $error("stalled result changed");

endmodule

>>> verif/euler_angles_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion_test: self-checking bench for the XYZ converter
// Sends angle beats through the valid/ready input channel, predicts each
// quaternion with a bit-exact CORDIC and product model, and checks every
// output beat in order under several idle and stall patterns.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion_test;

    typedef logic signed [eaq_pkg::ANGLE_WIDTH-1:0]     t_angle;
    typedef logic signed [eaq_pkg::COMPONENT_WIDTH-1:0] t_comp;
    typedef struct packed {
        t_angle ax;
        t_angle ay;
        t_angle az;
    } t_angles;
    typedef struct packed {
        t_comp w;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_quat;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     HOLD_OFF_LEN = 200;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid = 1'b0;
    logic   o_in_ready;
    t_angle i_angle_x = '0;
    t_angle i_angle_y = '0;
    t_angle i_angle_z = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_comp  o_quat_w;
    t_comp  o_quat_x;
    t_comp  o_quat_y;
    t_comp  o_quat_z;

    t_angles pending_angles[$];
    t_quat   expected_quats[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off_go = 1'b0;
    int      hold_off_count = 0;
    bit      failed = 1'b0;
    longint  cycle_count = 0;

    // Input accept seen at the rising edge; the driver uses it at the following falling edge.
    logic o_in_ready_q = 1'b0;

    euler_angles_to_quaternion i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_angle_x   (i_angle_x),
        .i_angle_y   (i_angle_y),
        .i_angle_z   (i_angle_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_quat_w    (o_quat_w),
        .o_quat_x    (o_quat_x),
        .o_quat_y    (o_quat_y),
        .o_quat_z    (o_quat_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Round to nearest, ties toward plus infinity (>>> floors).
    function automatic longint round_down(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat_q(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< eaq_pkg::FRAC_BITS) - 1;
        lo = -(64'sd1 <<< eaq_pkg::FRAC_BITS);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Cosine and sine of half the binary angle, Q1.F.
    function automatic void half_angle_trig(input t_angle a, output longint c,
                                            output longint s);
        longint xr;
        longint yr;
        longint zr;
        longint dx;
        longint dy;
        longint turn;
        xr = longint'(eaq_pkg::CORDIC_START);
        yr = 0;
        zr = longint'(a) * (64'sd1 <<< eaq_pkg::ANGLE_SHIFT);
        for (int i = 0; i < eaq_pkg::CORDIC_STEPS; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            turn = longint'(eaq_pkg::ATAN_TURN[i]) * 2;
            if (zr >= 0) begin
                xr = xr - dx; yr = yr + dy; zr = zr - turn;
            end else begin
                xr = xr + dx; yr = yr - dy; zr = zr + turn;
            end
        end
        c = sat_q(round_down(xr, eaq_pkg::ROUND_SHIFT));
        s = sat_q(round_down(yr, eaq_pkg::ROUND_SHIFT));
    endfunction

    function automatic longint triple(longint a, longint b, longint c);
        return round_down(round_down(a * b, eaq_pkg::FRAC_BITS) * c, eaq_pkg::FRAC_BITS);
    endfunction

    function automatic t_quat angles_to_quat(t_angles a);
        longint cx, sx, cy, sy, cz, sz;
        t_quat q;
        half_angle_trig(a.ax, cx, sx);
        half_angle_trig(a.ay, cy, sy);
        half_angle_trig(a.az, cz, sz);
        q.w = t_comp'(sat_q(triple(cx, cy, cz) + triple(sx, sy, sz)));
        q.x = t_comp'(sat_q(triple(sx, cy, cz) - triple(cx, sy, sz)));
        q.y = t_comp'(sat_q(triple(cx, sy, cz) + triple(sx, cy, sz)));
        q.z = t_comp'(sat_q(triple(cx, cy, sz) - triple(sx, sy, cz)));
        return q;
    endfunction

    // Driver: present the head of the queue at the falling edge, pop on accept.
    always @(negedge i_clk) begin
        if (i_in_valid && o_in_ready_q) begin
            void'(pending_angles.pop_front());
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if ((i_in_valid && !o_in_ready_q) ) begin
            // hold the beat until accepted
        end else if (pending_angles.size() != 0 &&
                     $urandom_range(99, 0) >= send_idle_pct) begin
            i_in_valid <= 1'b1;
            {i_angle_x, i_angle_y, i_angle_z} <= pending_angles[0];
        end else begin
            i_in_valid <= 1'b0;
        end
        if (hold_off_go && hold_off_count < HOLD_OFF_LEN) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted in cycles once started.
    always @(posedge i_clk) begin
        if (hold_off_go && hold_off_count < HOLD_OFF_LEN) begin
            hold_off_count <= hold_off_count + 1;
        end
    end

    // Monitor: predict on input accept, check on output accept.
    always @(posedge i_clk) begin
        t_quat got;
        t_quat want;
        o_in_ready_q <= i_rst_n && i_in_valid && o_in_ready;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_quats.push_back(angles_to_quat({i_angle_x, i_angle_y, i_angle_z}));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_quat_w, o_quat_x, o_quat_y, o_quat_z};
            if (expected_quats.size() == 0) begin
                $display("%0t: unexpected beat w=%0d x=%0d y=%0d z=%0d", $time,
                         got.w, got.x, got.y, got.z);
                failed <= 1'b1;
            end else begin
                want = expected_quats.pop_front();
                if (got.w !== want.w) begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
                    failed <= 1'b1;
                end
                if (got.x !== want.x) begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
                    failed <= 1'b1;
                end
                if (got.y !== want.y) begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
                    failed <= 1'b1;
                end
                if (got.z !== want.z) begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
                    failed <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if nothing converges.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("euler_angles_to_quaternion test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_angles.size() != 0 || i_in_valid || expected_quats.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_random(int count);
        t_angles a;
        for (int i = 0; i < count; i++) begin
            a.ax = t_angle'($urandom());
            a.ay = t_angle'($urandom());
            a.az = t_angle'($urandom());
            // Bias at most one lane toward the wrap points or zero.
            case ($urandom_range(7, 0))
                0: a.ax = 16'sh8000 + t_angle'($urandom_range(3, 0));
                1: a.ay = 16'sh7FFF - t_angle'($urandom_range(3, 0));
                2: a.az = t_angle'($urandom_range(4, 0)) - 2;
                default: ;
            endcase
            pending_angles.push_back(a);
        end
    endtask

    initial begin
        t_angle edge_vals[6];
        edge_vals = '{16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};
        i_rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each angle swept over its extremes, others fixed, plus all
        // three at minus pi (half angle -pi/2, exact -1.0 sine), at 0x7FFF and at pi/2.
        foreach (edge_vals[k]) begin
            pending_angles.push_back('{edge_vals[k], 16'sh0000, 16'sh0000});
            pending_angles.push_back('{16'sh0000, edge_vals[k], 16'sh0000});
            pending_angles.push_back('{16'sh2000, 16'shE000, edge_vals[k]});
        end
        pending_angles.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        pending_angles.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        pending_angles.push_back('{16'sh4000, 16'sh4000, 16'sh4000});
        wait_drained();

        // Phase: no idling.
        push_random(150);
        wait_drained();
        // Phase: sender idle.
        send_idle_pct = 58;
        push_random(120);
        wait_drained();
        // Phase: receiver stalls.
        send_idle_pct = 0;
        recv_stall_pct = 58;
        push_random(120);
        wait_drained();
        // Phase: long receiver hold-off while the sender keeps offering.
        recv_stall_pct = 0;
        hold_off_go = 1'b1;
        push_random(90);
        wait_drained();
        // Phase: both idle lightly.
        send_idle_pct = 9;
        recv_stall_pct = 9;
        push_random(120);
        wait_drained();

        repeat (eaq_pkg::LATENCY + 10) @(posedge i_clk);
        if (failed) begin
            $display("euler_angles_to_quaternion test failed");
        end else begin
            $display("euler_angles_to_quaternion test passed");
        end
        $finish;
    end
endmodule
